// ----- src/psem_pkg.sv -----
// ----------------------------------------------------------------------------
// psem_pkg: shared types and constants for the power status event monitor
// Sample and result word layouts, configuration register indexes and
// the effective configuration bundle.
// ----------------------------------------------------------------------------
package psem_pkg;

  localparam int unsigned LevelW    = 7;
  localparam int unsigned CountW    = 8;
  localparam int unsigned FlagsW    = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CountW-1:0] DebounceDefault = 8'd2;
  localparam logic [LevelW-1:0] DeltaDefault    = 7'd1;
  localparam logic [LevelW-1:0] LowDefault      = 7'd0;
  localparam logic [LevelW-1:0] RecoverDefault  = 7'd3;
  localparam logic [LevelW-1:0] RecoverMargin   = 7'd3;
  localparam logic [LevelW-1:0] LevelFull       = 7'd100;
  localparam logic [LevelW-1:0] LowMarginLimit  = 7'd97;
  localparam logic [CountW-1:0] CountMax        = 8'd255;

  // Event flag bit positions
  localparam int unsigned EvInitial  = 0;
  localparam int unsigned EvSupply   = 1;
  localparam int unsigned EvCharging = 2;
  localparam int unsigned EvStandby  = 3;
  localparam int unsigned EvBattery  = 4;
  localparam int unsigned EvPercent  = 5;
  localparam int unsigned EvLow      = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DELTA    = 2'd1,
    CFG_LOW      = 2'd2,
    CFG_RECOVER  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              supply_in;
    logic              charging_in;
    logic              standby_in;
    logic              battery_in;
    logic              level_valid_in;
    logic [LevelW-1:0] level_in;
  } sample_t;

  typedef struct packed {
    logic [FlagsW-1:0] event_flags;
    logic              entered_charge;
    logic              exited_charge;
    logic              refresh_request;
    logic              supply_out;
    logic              charging_out;
    logic              standby_out;
    logic              battery_out;
    logic              level_valid_out;
    logic [LevelW-1:0] level_out;
  } result_t;

  // Effective settings, defaults already substituted
  typedef struct packed {
    logic [CountW-1:0] debounce;
    logic [LevelW-1:0] delta;
    logic [LevelW-1:0] low;
    logic [LevelW-1:0] recover;
  } eff_cfg_t;

endpackage

// ----- src/power_status_event_monitor_top.sv -----
// Path: an accepted sample passes the input register, then the result register,
//   before its result word is offered.
// Throughput: one word per cycle when out_ready_i is high; the input register and the result register
//   both advance in the same cycle whenever the result side takes its word.
// Reset: asynchronous, active low; clears monitor state and both stage valids,
//   and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// power_status_event_monitor_top: power status event monitor
// Debounces supply presence, flags charger and battery bit changes, reports
// battery percent on change and raises a low-battery alarm with hysteresis.
// ----------------------------------------------------------------------------
module power_status_event_monitor_top import psem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Sample channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sample_t             in_data_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output result_t             out_data_o
);

  eff_cfg_t eff_cfg;
  result_t  result;
  logic     started;

  // Input register: holds the sample under evaluation
  logic    in_valid_q;
  sample_t in_data_q;
  // Result register
  logic    out_valid_q;
  result_t out_data_q;

  logic advance;

  // Move the held sample into the result register when that slot is free
  // or is being emptied this cycle; the state updates on the same edge.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  psem_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .eff_o      (eff_cfg)
  );

  psem_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .sample_i  (in_data_q),
    .cfg_i     (eff_cfg),
    .result_o  (result),
    .started_o (started)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A held sample with an empty result slot always moves on next cycle
  a_advance_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("held sample did not reach the result register");

  // Initial flag only appears while the monitor has not started
  a_initial_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result.event_flags[EvInitial] |-> !started)
    else $error("initial flag raised after first sample");

  // An exit comes with a supply change and never with an entry
  a_exit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.exited_charge |->
      out_data_o.event_flags[EvSupply] && !out_data_o.entered_charge)
    else $error("exit without supply change flag");

  // Low alarm only fires on battery power with a battery present
  a_low_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_flags[EvLow] |->
      !out_data_o.supply_out && out_data_o.battery_out)
    else $error("low alarm raised on supply or without battery");

endmodule

// ----- src/psem_cfg.sv -----
// ----------------------------------------------------------------------------
// psem_cfg: configuration registers
// Holds the four settings and derives their effective values.
// ----------------------------------------------------------------------------
module psem_cfg import psem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output eff_cfg_t            eff_o
);

  logic [CountW-1:0] debounce_q;
  logic [LevelW-1:0] delta_q;
  logic [LevelW-1:0] low_q;
  logic [LevelW-1:0] recover_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceDefault;
      delta_q    <= DeltaDefault;
      low_q      <= LowDefault;
      recover_q  <= RecoverDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_DELTA:    delta_q    <= cfg_data_i[LevelW-1:0];
        CFG_LOW:      low_q      <= cfg_data_i[LevelW-1:0];
        CFG_RECOVER:  recover_q  <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_o.debounce = (debounce_q == '0) ? DebounceDefault : debounce_q;
    eff_o.delta    = (delta_q == '0) ? DeltaDefault : delta_q;
    eff_o.low      = low_q;
    // Fall back to low plus a margin, capped at full charge
    if (recover_q > low_q) begin
      eff_o.recover = recover_q;
    end else if (low_q > LowMarginLimit) begin
      eff_o.recover = LevelFull;
    end else begin
      eff_o.recover = low_q + RecoverMargin;
    end
  end

endmodule

// ----- src/psem_eval.sv -----
// ----------------------------------------------------------------------------
// psem_eval: per-sample evaluation and monitor state
// Computes the result word for one sample and advances the state.
// ----------------------------------------------------------------------------
module psem_eval import psem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  sample_t  sample_i,
  input  eff_cfg_t cfg_i,
  output result_t  result_o,
  output logic     started_o
);

  logic              started_q, started_d;
  logic              stable_q, stable_d;
  logic              cand_q, cand_d;
  logic [CountW-1:0] count_q, count_d;
  logic              last_chg_q, last_stb_q, last_bat_q;
  logic [LevelW-1:0] rep_level_q, rep_level_d;
  logic              rep_valid_q, rep_valid_d;
  logic              low_q, low_d;

  logic [CountW-1:0] count_inc;
  logic [LevelW-1:0] diff;
  logic [FlagsW-1:0] flags;
  logic              entered, exited;

  always_comb begin
    started_d   = 1'b1;
    stable_d    = stable_q;
    cand_d      = cand_q;
    count_d     = count_q;
    rep_level_d = rep_level_q;
    rep_valid_d = rep_valid_q;
    low_d       = low_q;
    flags       = '0;
    entered     = 1'b0;
    exited      = 1'b0;
    count_inc   = '0;
    diff        = (sample_i.level_in >= rep_level_q) ? sample_i.level_in - rep_level_q
                                                     : rep_level_q - sample_i.level_in;

    if (!started_q) begin
      // Latch everything on the first word
      stable_d          = sample_i.supply_in;
      cand_d            = sample_i.supply_in;
      count_d           = '0;
      flags[EvInitial]  = 1'b1;
      if (sample_i.level_valid_in) begin
        flags[EvPercent] = 1'b1;
        rep_level_d      = sample_i.level_in;
        rep_valid_d      = 1'b1;
      end
      entered = sample_i.supply_in;
    end else begin
      if (sample_i.supply_in == stable_q) begin
        cand_d  = sample_i.supply_in;
        count_d = '0;
      end else begin
        if (sample_i.supply_in != cand_q) begin
          count_inc = 8'd1;
        end else if (count_q < CountMax) begin
          count_inc = count_q + 8'd1;
        end else begin
          count_inc = count_q;
        end
        cand_d  = sample_i.supply_in;
        count_d = count_inc;
        if (count_inc >= cfg_i.debounce) begin
          stable_d        = sample_i.supply_in;
          count_d         = '0;
          flags[EvSupply] = 1'b1;
          entered         = sample_i.supply_in;
          exited          = !sample_i.supply_in;
        end
      end
      flags[EvCharging] = sample_i.charging_in != last_chg_q;
      flags[EvStandby]  = sample_i.standby_in != last_stb_q;
      flags[EvBattery]  = sample_i.battery_in != last_bat_q;
      if (sample_i.level_valid_in &&
          (!rep_valid_q || diff >= cfg_i.delta ||
           (sample_i.level_in == '0 && rep_level_q != '0))) begin
        flags[EvPercent] = 1'b1;
        rep_level_d      = sample_i.level_in;
        rep_valid_d      = 1'b1;
      end
    end

    // Low-battery alarm with hysteresis, only on battery power
    if (stable_d || !sample_i.battery_in) begin
      low_d = 1'b0;
    end else if (sample_i.level_valid_in) begin
      if (low_q) begin
        low_d = sample_i.level_in < cfg_i.recover;
      end else begin
        low_d        = sample_i.level_in <= cfg_i.low;
        flags[EvLow] = low_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      stable_q    <= 1'b0;
      cand_q      <= 1'b0;
      count_q     <= '0;
      last_chg_q  <= 1'b0;
      last_stb_q  <= 1'b0;
      last_bat_q  <= 1'b0;
      rep_level_q <= '0;
      rep_valid_q <= 1'b0;
      low_q       <= 1'b0;
    end else if (advance_i) begin
      started_q   <= started_d;
      stable_q    <= stable_d;
      cand_q      <= cand_d;
      count_q     <= count_d;
      last_chg_q  <= sample_i.charging_in;
      last_stb_q  <= sample_i.standby_in;
      last_bat_q  <= sample_i.battery_in;
      rep_level_q <= rep_level_d;
      rep_valid_q <= rep_valid_d;
      low_q       <= low_d;
    end
  end

  always_comb begin
    result_o.event_flags     = flags;
    result_o.entered_charge  = entered;
    result_o.exited_charge   = exited;
    result_o.refresh_request = exited;
    result_o.supply_out      = stable_d;
    result_o.charging_out    = sample_i.charging_in;
    result_o.standby_out     = sample_i.standby_in;
    result_o.battery_out     = sample_i.battery_in;
    result_o.level_valid_out = sample_i.level_valid_in;
    result_o.level_out       = sample_i.level_in;
  end

  assign started_o = started_q;

endmodule
